>>> sv/bc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Register indexes, field widths and compensation constants.
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OSS   = 2'd3;

  localparam logic [1:0] OSS_RESET = 2'd1;

  // temperature divider: |MC*2048| over |X1+MD|
  localparam int TDIV_NW = 27;
  localparam int TDIV_DW = 18;
  // pressure divider: scaled B7 over B4
  localparam int PDIV_NW = 32;
  localparam int PDIV_DW = 17;

  localparam int          T_OFFSET  = 4000;
  localparam int          B4_BIAS   = 32768;
  localparam logic [15:0] P_SCALE   = 16'd50000;
  localparam logic [11:0] P_C1      = 12'd3038;
  localparam logic [12:0] P_C2_NEG  = 13'd7357;
  localparam int          P_C3      = 3791;

endpackage

>>> sv/bc_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, unsigned operands, sideband carried alongside.
// ----------------------------------------------------------------------------
module bc_div #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic [NW:1]   vld_r;
  logic [DW-1:0] rem_r  [1:NW];
  logic [NW-1:0] quo_r  [1:NW];
  logic [DW-1:0] den_r  [1:NW];
  logic [SW-1:0] side_r [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vld_i;
    logic [DW-1:0] rem_i;
    logic [NW-1:0] quo_i;
    logic [DW-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign quo_i  = in_num;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k];
      assign rem_i  = rem_r[k];
      assign quo_i  = quo_r[k];
      assign den_i  = den_r[k];
      assign side_i = side_r[k];
    end

    assign sh   = {rem_i, quo_i[NW-1]};
    assign ge   = sh >= {1'b0, den_i};
    assign diff = sh - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
        quo_r[k+1]  <= {quo_i[NW-2:0], ge};
        den_r[k+1]  <= den_i;
        side_r[k+1] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[NW];
  assign out_quot = quo_r[NW];
  assign out_side = side_r[NW];

endmodule

>>> sv/barometer_compensation.sv
// ----------------------------------------------------------------------------
// Barometer compensation
// Integer temperature and pressure compensation from raw sensor words.
// Depth: 76 register stages from the input to out_valid.
// Throughput: one item per cycle; the 27-stage and 32-stage divider pipelines
// set the depth, the whole pipeline holds while the output item is stalled.
// Reset: synchronous active-low; clears all valid bits, calibration words to
// zero and oversampling mode to 1.
// ----------------------------------------------------------------------------
module barometer_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_raw_temperature,
  input  logic [7:0]                    in_pressure_msb,
  input  logic [7:0]                    in_pressure_lsb,
  input  logic [7:0]                    in_pressure_xlsb,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_temperature_tenths,
  output logic [17:0]                   out_pressure_pa,
  output logic                          out_divide_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                   cfg_data
);

  import bc_pkg::*;

  localparam int TSW = 1 + 1 + 20 + 19;
  localparam int PSW = 16 + 1 + 1;

  logic        adv;
  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;

  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= OSS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAL_A: cal_a_r <= cfg_data;
        REG_CAL_B: cal_b_r <= cfg_data;
        REG_CAL_C: cal_c_r <= cfg_data[31:0];
        REG_OSS:   oss_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign ac1 = cal_a_r[15:0];
  assign ac2 = cal_a_r[31:16];
  assign ac3 = cal_a_r[47:32];
  assign ac4 = cal_a_r[63:48];
  assign ac5 = cal_b_r[15:0];
  assign ac6 = cal_b_r[31:16];
  assign b1  = cal_b_r[47:32];
  assign b2  = cal_b_r[63:48];
  assign mc  = cal_c_r[15:0];
  assign md  = cal_c_r[31:16];

  logic        out_valid_r;
  logic [15:0] out_temp_r;
  logic [17:0] out_pres_r;
  logic        out_err_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 1: raw pressure alignment, UT - AC6
  logic [23:0] up_all;
  logic [3:0]  up_sh;
  logic [18:0] up1_nxt;
  logic [17:0] d1_nxt;
  logic        v1_r;
  logic [18:0] up1_r;
  logic [17:0] d1_r;

  assign up_all  = {in_pressure_msb, in_pressure_lsb, in_pressure_xlsb};
  assign up_sh   = 4'd8 - {2'b00, oss_r};
  assign up1_nxt = 19'(up_all >> up_sh);
  assign d1_nxt  = {2'b00, in_raw_temperature} - {2'b00, ac6};

  // stage 2: X1
  logic signed [34:0] prod2;
  logic               v2_r;
  logic [18:0]        up2_r;
  logic [19:0]        x1_2_r;

  assign prod2 = $signed(d1_r) * $signed({1'b0, ac5});

  // stage 3: divider operands
  logic [20:0]         den3;
  logic [20:0]         den3_abs;
  logic [15:0]         mc_abs;
  logic                v3_r;
  logic [TDIV_NW-1:0]  num3_r;
  logic [TDIV_DW-1:0]  den3_r;
  logic [TSW-1:0]      side3_r;

  assign den3     = {x1_2_r[19], x1_2_r} + {{5{md[15]}}, md};
  assign den3_abs = den3[20] ? (21'd0 - den3) : den3;
  assign mc_abs   = mc[15] ? (16'd0 - mc) : mc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      up1_r   <= up1_nxt;
      d1_r    <= d1_nxt;
      up2_r   <= up1_r;
      x1_2_r  <= prod2[34:15];
      num3_r  <= {mc_abs, 11'd0};
      den3_r  <= den3_abs[TDIV_DW-1:0];
      side3_r <= {mc[15] ^ den3[20], den3 == 21'd0, x1_2_r, up2_r};
    end
  end

  logic               vdt;
  logic [TDIV_NW-1:0] qt;
  logic [TSW-1:0]     sidet;

  bc_div #(
    .NW(TDIV_NW),
    .DW(TDIV_DW),
    .SW(TSW)
  ) u_tdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (v3_r),
    .in_num  (num3_r),
    .in_den  (den3_r),
    .in_side (side3_r),
    .out_vld (vdt),
    .out_quot(qt),
    .out_side(sidet)
  );

  // stage 4: B5
  logic        negq_t, zero_t;
  logic [19:0] x1_t;
  logic [18:0] up_t;
  logic [27:0] x2_4;
  logic [28:0] b5_nxt;
  logic        v4_r;
  logic [28:0] b5_4_r;
  logic [18:0] up4_r;
  logic        err4_r;

  assign {negq_t, zero_t, x1_t, up_t} = sidet;
  assign x2_4   = negq_t ? (28'd0 - {1'b0, qt}) : {1'b0, qt};
  assign b5_nxt = {{9{x1_t[19]}}, x1_t} + {x2_4[27], x2_4};

  // stage 5: B6, temperature
  logic [28:0] b6_nxt;
  logic [28:0] tt5;
  logic [24:0] tq5;
  logic [15:0] t5_nxt;
  logic        v5_r;
  logic [28:0] b6_5_r;
  logic [15:0] t5_r;
  logic [18:0] up5_r;
  logic        err5_r;

  assign b6_nxt = b5_4_r - 29'(T_OFFSET);
  assign tt5    = b5_4_r + 29'd8;
  assign tq5    = tt5[28:4];

  always_comb begin
    if (!tq5[24] && (|tq5[23:15])) begin
      t5_nxt = 16'h7FFF;
    end else if (tq5[24] && !(&tq5[23:15])) begin
      t5_nxt = 16'h8000;
    end else begin
      t5_nxt = tq5[15:0];
    end
  end

  // stage 6: B6 squared, AC2*B6, AC3*B6
  logic signed [57:0] sqp6;
  logic signed [44:0] ac2m6;
  logic signed [44:0] ac3m6;
  logic               v6_r;
  logic [41:0]        sq6_r;
  logic [33:0]        x2b6_r;
  logic [31:0]        x1c6_r;
  logic [15:0]        t6_r;
  logic [18:0]        up6_r;
  logic               err6_r;

  assign sqp6  = $signed(b6_5_r) * $signed(b6_5_r);
  assign ac2m6 = $signed(ac2) * $signed(b6_5_r);
  assign ac3m6 = $signed(ac3) * $signed(b6_5_r);

  // stage 7: B2*SQ, B1*SQ
  logic signed [58:0] b2m7;
  logic signed [58:0] b1m7;
  logic               v7_r;
  logic [47:0]        x1a7_r;
  logic [42:0]        x2c7_r;
  logic [33:0]        x2b7_r;
  logic [31:0]        x1c7_r;
  logic [15:0]        t7_r;
  logic [18:0]        up7_r;
  logic               err7_r;

  assign b2m7 = $signed(b2) * $signed({1'b0, sq6_r});
  assign b1m7 = $signed(b1) * $signed({1'b0, sq6_r});

  // stage 8: B3 numerator, X3 for B4
  logic [48:0] x3_8;
  logic [49:0] vsum8;
  logic [52:0] vext8;
  logic [43:0] s8;
  logic        v8_r;
  logic [52:0] vsh8_r;
  logic [31:0] x3p8_r;
  logic [15:0] t8_r;
  logic [18:0] up8_r;
  logic        err8_r;

  assign x3_8  = {x1a7_r[47], x1a7_r} + {{15{x2b7_r[33]}}, x2b7_r};
  assign vsum8 = {x3_8[48], x3_8} + {{32{ac1[15]}}, ac1, 2'b00};
  assign vext8 = {{3{vsum8[49]}}, vsum8};
  assign s8    = {{12{x1c7_r[31]}}, x1c7_r} + {x2c7_r[42], x2c7_r} + 44'd2;

  // stage 9: B3 low word, B4
  logic [52:0] w9;
  logic [52:0] wb9;
  logic [47:0] b4m9;
  logic        v9_r;
  logic [31:0] b3_9_r;
  logic [16:0] b4_9_r;
  logic [15:0] t9_r;
  logic [18:0] up9_r;
  logic        err9_r;

  assign w9   = vsh8_r + 53'd2;
  assign wb9  = w9 + (w9[52] ? 53'd3 : 53'd0);
  assign b4m9 = ac4 * x3p8_r;

  // stage 10: UP - B3
  logic        v10_r;
  logic [31:0] b7a10_r;
  logic [16:0] b4_10_r;
  logic [15:0] t10_r;
  logic        err10_r;

  // stage 11: B7
  logic [15:0] scale11;
  logic [47:0] b7m11;
  logic        v11_r;
  logic [31:0] b7_11_r;
  logic [16:0] b4_11_r;
  logic [15:0] t11_r;
  logic        err11_r;

  assign scale11 = P_SCALE >> oss_r;
  assign b7m11   = b7a10_r * scale11;

  // stage 12: divider operands
  logic               v12_r;
  logic [PDIV_NW-1:0] num12_r;
  logic [PDIV_DW-1:0] den12_r;
  logic [PSW-1:0]     side12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else if (adv) begin
      v4_r  <= vdt;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_4_r   <= b5_nxt;
      up4_r    <= up_t;
      err4_r   <= zero_t;

      b6_5_r   <= b6_nxt;
      t5_r     <= t5_nxt;
      up5_r    <= up4_r;
      err5_r   <= err4_r;

      sq6_r    <= sqp6[53:12];
      x2b6_r   <= ac2m6[44:11];
      x1c6_r   <= ac3m6[44:13];
      t6_r     <= t5_r;
      up6_r    <= up5_r;
      err6_r   <= err5_r;

      x1a7_r   <= b2m7[58:11];
      x2c7_r   <= b1m7[58:16];
      x2b7_r   <= x2b6_r;
      x1c7_r   <= x1c6_r;
      t7_r     <= t6_r;
      up7_r    <= up6_r;
      err7_r   <= err6_r;

      vsh8_r   <= vext8 << oss_r;
      x3p8_r   <= s8[33:2] + 32'(B4_BIAS);
      t8_r     <= t7_r;
      up8_r    <= up7_r;
      err8_r   <= err7_r;

      b3_9_r   <= wb9[33:2];
      b4_9_r   <= b4m9[31:15];
      t9_r     <= t8_r;
      up9_r    <= up8_r;
      err9_r   <= err8_r;

      b7a10_r  <= {13'd0, up9_r} - b3_9_r;
      b4_10_r  <= b4_9_r;
      t10_r    <= t9_r;
      err10_r  <= err9_r;

      b7_11_r  <= b7m11[31:0];
      b4_11_r  <= b4_10_r;
      t11_r    <= t10_r;
      err11_r  <= err10_r;

      num12_r  <= b7_11_r[31] ? b7_11_r : {b7_11_r[30:0], 1'b0};
      den12_r  <= b4_11_r;
      side12_r <= {t11_r, b7_11_r[31], err11_r || (b4_11_r == 17'd0)};
    end
  end

  logic               vdp;
  logic [PDIV_NW-1:0] qp;
  logic [PSW-1:0]     sidep;

  bc_div #(
    .NW(PDIV_NW),
    .DW(PDIV_DW),
    .SW(PSW)
  ) u_pdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (v12_r),
    .in_num  (num12_r),
    .in_den  (den12_r),
    .in_side (side12_r),
    .out_vld (vdp),
    .out_quot(qp),
    .out_side(sidep)
  );

  // stage 13: raw pressure
  logic [15:0] t_p;
  logic        big_p, err_p;
  logic        v13_r;
  logic [32:0] p13_r;
  logic [15:0] t13_r;
  logic        err13_r;

  assign {t_p, big_p, err_p} = sidep;

  // stage 14: (P>>8)^2, 7357*P
  logic [49:0] sqp14;
  logic [45:0] m2p14;
  logic        v14_r;
  logic [49:0] sqp14_r;
  logic [45:0] m2p14_r;
  logic [32:0] p14_r;
  logic [15:0] t14_r;
  logic        err14_r;

  assign sqp14 = p13_r[32:8] * p13_r[32:8];
  assign m2p14 = p13_r * P_C2_NEG;

  // stage 15: X1, X2
  logic [61:0] a15;
  logic [46:0] neg15;
  logic        v15_r;
  logic [45:0] x1_15_r;
  logic [30:0] x2_15_r;
  logic [32:0] p15_r;
  logic [15:0] t15_r;
  logic        err15_r;

  assign a15   = sqp14_r * P_C1;
  assign neg15 = 47'd0 - {1'b0, m2p14_r};

  // stage 16: corrected pressure
  logic [47:0] s16;
  logic [43:0] corr16;
  logic        v16_r;
  logic [45:0] pf16_r;
  logic [15:0] t16_r;
  logic        err16_r;

  assign s16    = {2'b00, x1_15_r} + {{17{x2_15_r[30]}}, x2_15_r} + 48'(P_C3);
  assign corr16 = s16[47:4];

  // output stage: saturate
  logic [17:0] pres_nxt;

  always_comb begin
    if (pf16_r[45]) begin
      pres_nxt = '0;
    end else if (|pf16_r[44:18]) begin
      pres_nxt = '1;
    end else begin
      pres_nxt = pf16_r[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r       <= 1'b0;
      v14_r       <= 1'b0;
      v15_r       <= 1'b0;
      v16_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v13_r       <= vdp;
      v14_r       <= v13_r;
      v15_r       <= v14_r;
      v16_r       <= v15_r;
      out_valid_r <= v16_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p13_r      <= big_p ? {qp, 1'b0} : {1'b0, qp};
      t13_r      <= t_p;
      err13_r    <= err_p;

      sqp14_r    <= sqp14;
      m2p14_r    <= m2p14;
      p14_r      <= p13_r;
      t14_r      <= t13_r;
      err14_r    <= err13_r;

      x1_15_r    <= a15[61:16];
      x2_15_r    <= neg15[46:16];
      p15_r      <= p14_r;
      t15_r      <= t14_r;
      err15_r    <= err14_r;

      pf16_r     <= {13'd0, p15_r} + {{2{corr16[43]}}, corr16};
      t16_r      <= t15_r;
      err16_r    <= err15_r;

      out_temp_r <= err16_r ? 16'd0 : t16_r;
      out_pres_r <= err16_r ? 18'd0 : pres_nxt;
      out_err_r  <= err16_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_pressure_pa        = out_pres_r;
  assign out_divide_error       = out_err_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_temp_r == 16'd0 && out_pres_r == 18'd0)
    else $error("divide error item carries nonzero results");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> v1_r == $past(v1_r) && v12_r == $past(v12_r) && v16_r == $past(v16_r))
    else $error("pipeline valid moved while held");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input held with no output item waiting");
`endif

endmodule
